// ===== hdl/sdf_pkg.sv =====
`default_nettype none

package sdf_pkg;

  localparam int VAL_W   = 32;   // input value width
  localparam int FW_W    = 8;    // field_width width
  localparam int FLAG_W  = 2;    // format_flags width
  localparam int SIZE_W  = 12;   // buffer_size width
  localparam int CHAR_W  = 8;    // character width
  localparam int STAT_W  = 2;    // status width
  localparam int DIGITS  = 10;   // decimal digits of a 32-bit magnitude
  localparam int DCNT_W  = 4;    // holds a digit count up to 11
  localparam int STEP_W  = $clog2(VAL_W);

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

  localparam int FLAG_SIGN  = 0;   // always write a sign
  localparam int FLAG_SPACE = 1;   // pad with spaces

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_SHORT = 2'd2
  } sdf_status_t;

  typedef logic [DIGITS-1:0][3:0] sdf_bcd_t;

  // conversion unit status towards the sequencer
  typedef struct packed {
    logic              done;
    logic [DCNT_W-1:0] ndig;
  } sdf_bcd_stat_t;

endpackage

`default_nettype wire

// ===== hdl/sdf_in_if.sv =====
`default_nettype none

interface sdf_in_if
  import sdf_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [VAL_W-1:0]  value;
  logic [FW_W-1:0]   field_width;
  logic [FLAG_W-1:0] format_flags;
  logic [SIZE_W-1:0] buffer_size;

  modport source (output valid, output value, output field_width,
                  output format_flags, output buffer_size, input ready);
  modport sink   (input valid, input value, input field_width,
                  input format_flags, input buffer_size, output ready);
endinterface

`default_nettype wire

// ===== hdl/sdf_out_if.sv =====
`default_nettype none

interface sdf_out_if
  import sdf_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic [STAT_W-1:0] status;
  logic              last;

  modport source (output valid, output character, output status, output last,
                  input ready);
  modport sink   (input valid, input character, input status, input last,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/sdf_bcd.sv =====
`default_nettype none

// Bit-serial binary to BCD (shift and add-3), one input bit per cycle.
module sdf_bcd
  import sdf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start_i,
  input  wire logic [VAL_W-1:0] mag_i,
  output sdf_bcd_stat_t         stat_o,
  output sdf_bcd_t              digits_o
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [VAL_W-1:0]      shreg_r, shreg_nxt;
  sdf_bcd_t              bcd_r, bcd_nxt;
  sdf_bcd_t              adj;
  logic [DIGITS*4-1:0]   adj_flat;
  logic [DCNT_W-1:0]     ndig;
  logic                  digits_ok;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
  end

  assign adj_flat = adj;

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    step_nxt  = step_r;
    shreg_nxt = shreg_r;
    bcd_nxt   = bcd_r;
    if (start_i) begin
      busy_nxt  = 1'b1;
      step_nxt  = '0;
      shreg_nxt = mag_i;
      bcd_nxt   = '0;
    end else if (busy_r) begin
      bcd_nxt   = {adj_flat[DIGITS*4-2:0], shreg_r[VAL_W-1]};
      shreg_nxt = {shreg_r[VAL_W-2:0], 1'b0};
      step_nxt  = step_r + 1'b1;
      if (step_r == STEP_W'(VAL_W-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r  <= step_nxt;
    shreg_r <= shreg_nxt;
    bcd_r   <= bcd_nxt;
  end

  // leading digit position; zero still counts as one digit
  always_comb begin
    ndig = DCNT_W'(1);
    for (int i = 1; i < DIGITS; i++) begin
      if (bcd_r[i] != 4'd0) ndig = DCNT_W'(i + 1);
    end
  end

  always_comb begin
    digits_ok = 1'b1;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_r[i] > 4'd9) digits_ok = 1'b0;
    end
  end

  assign stat_o.done = done_r;
  assign stat_o.ndig = ndig;
  assign digits_o    = bcd_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |=> busy_r) else $error("conversion did not start");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("done while still shifting");
  a_digits: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> digits_ok) else $error("non-decimal digit after conversion");

endmodule

`default_nettype wire

// ===== hdl/signed_decimal_formatter.sv =====
`default_nettype none

// Channel  Port    Dir  Payload
// -------  ------  ---  ---------------------------------------------------
// input    in_if   in   value[31:0] field_width[7:0] format_flags[1:0]
//                       buffer_size[11:0]
// result   out_if  out  character[7:0] status[1:0] last
//
// One transaction in at a time; in_if.ready is high only when idle.
// Buffer size zero: one result.
// Otherwise the input is accepted, the bit-serial BCD converter runs
// (one value bit per cycle), its digits are taken up, then results follow
// at one per cycle while out_if.ready stays high (1 to 12 results).
// Reset is synchronous, active low, and clears the sequencer and the
// output valid. A stalled result holds in the output register and halts
// emission until taken.
module signed_decimal_formatter
  import sdf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  sdf_in_if.sink    in_if,
  sdf_out_if.source out_if
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic              neg_r, neg_nxt;
  logic [FW_W-1:0]   fw_r, fw_nxt;
  logic [FLAG_W-1:0] flags_r, flags_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  sdf_status_t       stat_r, stat_nxt;
  logic              sign_r, sign_nxt;
  logic [DCNT_W-1:0] pads_r, pads_nxt;
  logic [DCNT_W-1:0] dig_r, dig_nxt;

  logic              ovalid_r, ovalid_nxt;
  logic [CHAR_W-1:0] ochar_r, ochar_nxt;
  sdf_status_t       ostat_r, ostat_nxt;
  logic              olast_r, olast_nxt;

  logic              in_acc;
  logic              slot_free;
  logic              bcd_start;
  logic [VAL_W-1:0]  mag;
  sdf_bcd_stat_t     bcd_stat;
  sdf_bcd_t          digits;

  logic              s;
  logic [DCNT_W-1:0] lo, hi, w;
  logic              short;
  logic [DCNT_W-1:0] dig_idx;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign slot_free   = !ovalid_r || out_if.ready;
  assign bcd_start   = in_acc && (in_if.buffer_size != '0);
  // two's complement magnitude; the most negative value maps to 2^31
  assign mag = in_if.value[VAL_W-1] ? (~in_if.value + 1'b1) : in_if.value;

  sdf_bcd u_bcd (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (bcd_start),
    .mag_i    (mag),
    .stat_o   (bcd_stat),
    .digits_o (digits)
  );

  // width clamp to [digits + sign, 10 + sign]
  always_comb begin
    s  = neg_r | flags_r[FLAG_SIGN];
    lo = bcd_stat.ndig + DCNT_W'(s);
    hi = DCNT_W'(DIGITS) + DCNT_W'(s);
    if (fw_r < FW_W'(lo)) begin
      w = lo;
    end else if (fw_r > FW_W'(hi)) begin
      w = hi;
    end else begin
      w = fw_r[DCNT_W-1:0];
    end
    short   = (size_r <= SIZE_W'(w));
    dig_idx = dig_r - 1'b1;
  end

  always_comb begin
    state_nxt  = state_r;
    neg_nxt    = neg_r;
    fw_nxt     = fw_r;
    flags_nxt  = flags_r;
    size_nxt   = size_r;
    stat_nxt   = stat_r;
    sign_nxt   = sign_r;
    pads_nxt   = pads_r;
    dig_nxt    = dig_r;
    ovalid_nxt = ovalid_r && !out_if.ready;
    ochar_nxt  = ochar_r;
    ostat_nxt  = ostat_r;
    olast_nxt  = olast_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          neg_nxt   = in_if.value[VAL_W-1];
          fw_nxt    = in_if.field_width;
          flags_nxt = in_if.format_flags;
          size_nxt  = in_if.buffer_size;
          if (in_if.buffer_size == '0) begin
            stat_nxt  = ST_EMPTY;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_CONV;
          end
        end
      end
      S_CONV: begin
        if (bcd_stat.done) begin
          stat_nxt  = short ? ST_SHORT : ST_OK;
          sign_nxt  = s;
          pads_nxt  = w - bcd_stat.ndig - DCNT_W'(s);
          dig_nxt   = bcd_stat.ndig;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          ostat_nxt  = stat_r;
          olast_nxt  = 1'b0;
          if (stat_r != ST_OK) begin
            ochar_nxt = CH_NUL;
            olast_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else if (sign_r) begin
            ochar_nxt = neg_r ? CH_MINUS : CH_PLUS;
            sign_nxt  = 1'b0;
          end else if (pads_r != '0) begin
            ochar_nxt = flags_r[FLAG_SPACE] ? CH_SPACE : CH_ZERO;
            pads_nxt  = pads_r - 1'b1;
          end else if (dig_r != '0) begin
            ochar_nxt = CH_ZERO + CHAR_W'(digits[dig_idx]);
            dig_nxt   = dig_r - 1'b1;
          end else begin
            ochar_nxt = CH_NUL;
            olast_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
    neg_r   <= neg_nxt;
    fw_r    <= fw_nxt;
    flags_r <= flags_nxt;
    size_r  <= size_nxt;
    stat_r  <= stat_nxt;
    sign_r  <= sign_nxt;
    pads_r  <= pads_nxt;
    dig_r   <= dig_nxt;
    ochar_r <= ochar_nxt;
    ostat_r <= ostat_nxt;
    olast_r <= olast_nxt;
  end

  assign out_if.valid     = ovalid_r;
  assign out_if.character = ochar_r;
  assign out_if.status    = ostat_r;
  assign out_if.last      = olast_r;

  a_busy_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_if.ready) else $error("accepted while a transaction is open");
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && (ostat_r != ST_OK)) |-> (ochar_r == CH_NUL) && olast_r)
    else $error("error result is not a lone terminator");
  a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    bcd_stat.done |-> (state_r == S_CONV)) else $error("stray conversion done");

endmodule

`default_nettype wire
